// ===== hw/rtl/ipv4_dns_bgp_packet_classifier_macros.svh =====
// Assertion macros shared by the packet classifier modules
`ifndef IPV4_DNS_BGP_PACKET_CLASSIFIER_MACROS_SVH
`define IPV4_DNS_BGP_PACKET_CLASSIFIER_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define PKTCLS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pktcls assertion failed");

// Check a consequence in the cycle after its cause
`define PKTCLS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pktcls assertion failed");

`endif

// ===== hw/rtl/pktcls_pkg.sv =====
// Types and constants of the packet classifier
package pktcls_pkg;

   // Frame layout
   localparam int ETH_HEADER_BYTES = 14;
   localparam int MAX_FRAME_BYTES  = 65536;

   // Protocol constants
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [3:0]  IP_VERSION_4  = 4'd4;
   localparam logic [3:0]  IP_MIN_WORDS  = 4'd5;
   localparam int          UDP_HDR_BYTES = 8;
   localparam int          DNS_HDR_BYTES = 12;

   // Register defaults
   localparam logic [15:0] DNS_PORT_RESET = 16'd53;
   localparam logic [15:0] BGP_PORT_RESET = 16'd179;

   // Register indexes
   localparam logic CSR_DNS_PORT = 1'b0;
   localparam logic CSR_BGP_PORT = 1'b1;

   typedef enum logic [1:0] {
      CLASS_NONE    = 2'd0,
      CLASS_DNS_UDP = 2'd1,
      CLASS_DNS_TCP = 2'd2,
      CLASS_BGP_TCP = 2'd3
   } class_type;

   // Everything captured from one frame, handed to the classifier
   typedef struct packed {
      logic [3:0]  header_words;
      logic        ipv4_ok;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [31:0] ports;
      logic [15:0] udp_length;
      logic [63:0] dns_header;
      logic [16:0] have;
   } frame_sum_type;

   // One result word
   typedef struct packed {
      class_type   traffic_class;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port_num;
      logic [15:0] dst_port_num;
      logic        dns_header_valid;
      logic [15:0] dns_id;
      logic [15:0] dns_flags;
      logic [15:0] dns_questions;
      logic [15:0] dns_answers;
   } result_type;

endpackage

// ===== hw/rtl/pktcls_intf.sv =====
// Byte input channel and result channel of the packet classifier
interface pktcls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_last;

   modport source (output valid, output frame_byte, output frame_last, input ready);
   modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface pktcls_rsp_if;
   logic                  valid;
   logic                  ready;
   pktcls_pkg::class_type traffic_class;
   logic [31:0]           src_addr;
   logic [31:0]           dst_addr;
   logic [15:0]           src_port_num;
   logic [15:0]           dst_port_num;
   logic                  dns_header_valid;
   logic [15:0]           dns_id;
   logic [15:0]           dns_flags;
   logic [15:0]           dns_questions;
   logic [15:0]           dns_answers;

   modport source (output valid, output traffic_class, output src_addr, output dst_addr,
                   output src_port_num, output dst_port_num, output dns_header_valid,
                   output dns_id, output dns_flags, output dns_questions,
                   output dns_answers, input ready);
   modport sink   (input valid, input traffic_class, input src_addr, input dst_addr,
                   input src_port_num, input dst_port_num, input dns_header_valid,
                   input dns_id, input dns_flags, input dns_questions,
                   input dns_answers, output ready);
endinterface

// ===== hw/rtl/pktcls_capture.sv =====
// Byte capture stage: tracks the frame offset and collects header fields
`include "ipv4_dns_bgp_packet_classifier_macros.svh"

module pktcls_capture (
   input  logic                      clock,
   input  logic                      reset,
   pktcls_req_if.sink                req_chan,
   output logic                      sum_valid,
   output pktcls_pkg::frame_sum_type sum_data,
   input  logic                      sum_ready
);
   import pktcls_pkg::*;

   localparam logic [15:0] ETH_OFF   = 16'(ETH_HEADER_BYTES);
   localparam logic [16:0] MAX_LIMIT = 17'(MAX_FRAME_BYTES);

   logic [15:0]   off_ff, off_in;
   logic [3:0]    hw_ff, hw_in;
   logic          ok_ff, ok_in;
   logic [7:0]    proto_ff, proto_in;
   logic [31:0]   src_ff, src_in;
   logic [31:0]   dst_ff, dst_in;
   logic [31:0]   ports_ff, ports_in;
   logic [15:0]   udp_ff, udp_in;
   logic [63:0]   dns_ff, dns_in;
   logic          sum_v_ff;
   frame_sum_type sum_ff, sum_in;

   logic          req_acc;
   logic          cap_en;
   logic [7:0]    b;
   logic [15:0]   t_off;
   logic [15:0]   rel;
   logic [16:0]   have_raw;

   // Take a word whenever the summary slot is free or moving on
   assign req_chan.ready = !sum_v_ff || sum_ready;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign b              = req_chan.frame_byte;

   // Capture fields at their offsets
   always_comb begin
      hw_in    = hw_ff;
      ok_in    = ok_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      ports_in = ports_ff;
      udp_in   = udp_ff;
      dns_in   = dns_ff;
      cap_en   = {1'b0, off_ff} < MAX_LIMIT;
      t_off    = ETH_OFF + {10'd0, hw_ff, 2'b00};
      rel      = off_ff - t_off;
      if (cap_en) begin
         if (off_ff == ETH_OFF) begin
            hw_in = b[3:0];
            ok_in = (b[7:4] == IP_VERSION_4) && (b[3:0] >= IP_MIN_WORDS);
         end else if (off_ff == ETH_OFF + 16'd9) begin
            proto_in = b;
         end else if (off_ff >= ETH_OFF + 16'd12 && off_ff < ETH_OFF + 16'd16) begin
            src_in = {src_ff[23:0], b};
         end else if (off_ff >= ETH_OFF + 16'd16 && off_ff < ETH_OFF + 16'd20) begin
            dst_in = {dst_ff[23:0], b};
         end
         // Transport header fields; a valid header always starts past the IP fields
         if (ok_ff && off_ff >= t_off) begin
            if (rel < 16'd4) begin
               ports_in = {ports_ff[23:0], b};
            end else if (rel < 16'd6) begin
               udp_in = {udp_ff[7:0], b};
            end else if (rel >= 16'(UDP_HDR_BYTES) && rel < 16'(UDP_HDR_BYTES + 8)) begin
               dns_in = {dns_ff[55:0], b};
            end
         end
      end
   end

   // Advance the offset, saturating
   assign off_in   = (off_ff != 16'hffff) ? off_ff + 16'd1 : off_ff;
   assign have_raw = {1'b0, off_ff} + 17'd1;

   // Build the frame summary from the state after this word
   always_comb begin
      sum_in.header_words = hw_in;
      sum_in.ipv4_ok      = ok_in;
      sum_in.protocol     = proto_in;
      sum_in.src_addr     = src_in;
      sum_in.dst_addr     = dst_in;
      sum_in.ports        = ports_in;
      sum_in.udp_length   = udp_in;
      sum_in.dns_header   = dns_in;
      sum_in.have         = (have_raw > MAX_LIMIT) ? MAX_LIMIT : have_raw;
   end

   // Frame state: commit on each word, clear after the last
   always_ff @(posedge clock) begin
      if (reset || (req_acc && req_chan.frame_last)) begin
         off_ff   <= '0;
         hw_ff    <= '0;
         ok_ff    <= 1'b0;
         proto_ff <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
         ports_ff <= '0;
         udp_ff   <= '0;
         dns_ff   <= '0;
      end else if (req_acc) begin
         off_ff   <= off_in;
         hw_ff    <= hw_in;
         ok_ff    <= ok_in;
         proto_ff <= proto_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
         ports_ff <= ports_in;
         udp_ff   <= udp_in;
         dns_ff   <= dns_in;
      end
   end

   // Summary slot valid
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_v_ff <= 1'b0;
      end else if (req_chan.ready) begin
         sum_v_ff <= req_acc && req_chan.frame_last;
      end
   end

   // Summary payload
   always_ff @(posedge clock) begin
      if (req_acc && req_chan.frame_last) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_valid = sum_v_ff;
   assign sum_data  = sum_ff;

   `PKTCLS_ASSERT_NEXT(a_off_clear, clock, reset, req_acc && req_chan.frame_last, off_ff == '0)
   `PKTCLS_ASSERT_NEXT(a_sum_hold, clock, reset, sum_v_ff && !sum_ready, sum_v_ff && $stable(sum_ff))
   `PKTCLS_ASSERT_SAME(a_ok_words, clock, reset, ok_ff, hw_ff >= IP_MIN_WORDS)

endmodule

// ===== hw/rtl/pktcls_classify.sv =====
// Classification stage: port matching, DNS header check and result register
`include "ipv4_dns_bgp_packet_classifier_macros.svh"

module pktcls_classify (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      sum_valid,
   input  pktcls_pkg::frame_sum_type sum_data,
   output logic                      sum_ready,
   input  logic [15:0]               dns_port,
   input  logic [15:0]               bgp_port,
   pktcls_rsp_if.source              rsp_chan
);
   import pktcls_pkg::*;

   logic        res_v_ff;
   result_type  res_ff, res_in;

   logic [16:0] t_off;
   logic [15:0] sp, dp;
   logic        ports_ok, is_dns, is_bgp, dns_ok;
   class_type   cls;

   // Move the summary on when the result slot is free or being taken
   assign sum_ready = !res_v_ff || rsp_chan.ready;

   assign t_off = 17'(ETH_HEADER_BYTES) + {11'd0, sum_data.header_words, 2'b00};
   assign sp    = sum_data.ports[31:16];
   assign dp    = sum_data.ports[15:0];

   // Match ports and pick the class, DNS first
   always_comb begin
      ports_ok = sum_data.ipv4_ok && (sum_data.have >= t_off + 17'd4);
      is_dns   = (sp == dns_port) || (dp == dns_port);
      is_bgp   = (sp == bgp_port) || (dp == bgp_port);
      cls      = CLASS_NONE;
      if (ports_ok) begin
         if (sum_data.protocol == PROTO_UDP) begin
            if (is_dns) cls = CLASS_DNS_UDP;
         end else if (sum_data.protocol == PROTO_TCP) begin
            if (is_dns) begin
               cls = CLASS_DNS_TCP;
            end else if (is_bgp) begin
               cls = CLASS_BGP_TCP;
            end
         end
      end
      dns_ok = (cls == CLASS_DNS_UDP)
            && (sum_data.udp_length >= 16'(UDP_HDR_BYTES + DNS_HDR_BYTES))
            && (sum_data.have >= t_off + 17'(UDP_HDR_BYTES + DNS_HDR_BYTES));
   end

   // Form the result, zeroing what does not apply
   always_comb begin
      res_in = '0;
      if (cls != CLASS_NONE) begin
         res_in.traffic_class = cls;
         res_in.src_addr      = sum_data.src_addr;
         res_in.dst_addr      = sum_data.dst_addr;
         res_in.src_port_num  = sp;
         res_in.dst_port_num  = dp;
         if (dns_ok) begin
            res_in.dns_header_valid = 1'b1;
            res_in.dns_id           = sum_data.dns_header[63:48];
            res_in.dns_flags        = sum_data.dns_header[47:32];
            res_in.dns_questions    = sum_data.dns_header[31:16];
            res_in.dns_answers      = sum_data.dns_header[15:0];
         end
      end
   end

   // Result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         res_v_ff <= 1'b0;
      end else if (sum_ready) begin
         res_v_ff <= sum_valid;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (sum_ready && sum_valid) begin
         res_ff <= res_in;
      end
   end

   assign rsp_chan.valid            = res_v_ff;
   assign rsp_chan.traffic_class    = res_ff.traffic_class;
   assign rsp_chan.src_addr         = res_ff.src_addr;
   assign rsp_chan.dst_addr         = res_ff.dst_addr;
   assign rsp_chan.src_port_num     = res_ff.src_port_num;
   assign rsp_chan.dst_port_num     = res_ff.dst_port_num;
   assign rsp_chan.dns_header_valid = res_ff.dns_header_valid;
   assign rsp_chan.dns_id           = res_ff.dns_id;
   assign rsp_chan.dns_flags        = res_ff.dns_flags;
   assign rsp_chan.dns_questions    = res_ff.dns_questions;
   assign rsp_chan.dns_answers      = res_ff.dns_answers;

   `PKTCLS_ASSERT_SAME(a_dns_class, clock, reset, res_v_ff && res_ff.dns_header_valid, res_ff.traffic_class == CLASS_DNS_UDP)
   `PKTCLS_ASSERT_SAME(a_none_zero, clock, reset, res_v_ff && res_ff.traffic_class == CLASS_NONE, res_ff.src_addr == '0 && res_ff.dst_addr == '0 && res_ff.src_port_num == '0)

endmodule

// ===== hw/rtl/ipv4_dns_bgp_packet_classifier.sv =====
// A result word moves through the capture summary register, then the result register,
// after its frame's last byte is taken.
// Frame bytes are taken one per cycle while the summary slot is free or moving on;
// back-to-back frames then run at full rate, as the frame state clears on the last byte.
// Reset (synchronous): clears frame state and both output slots; the DNS port
// register returns to 53 and the BGP port register to 179.
module ipv4_dns_bgp_packet_classifier (
   input  logic          clock,
   input  logic          reset,
   pktcls_req_if.sink    req_chan,
   pktcls_rsp_if.source  rsp_chan,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [15:0]   csr_wdata
);
   import pktcls_pkg::*;

   logic [15:0]   dns_port_ff;
   logic [15:0]   bgp_port_ff;
   logic          sum_valid;
   logic          sum_ready;
   frame_sum_type sum_data;

   // Port registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dns_port_ff <= DNS_PORT_RESET;
         bgp_port_ff <= BGP_PORT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DNS_PORT: dns_port_ff <= csr_wdata;
            CSR_BGP_PORT: bgp_port_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   pktcls_capture u_capture (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .sum_valid (sum_valid),
      .sum_data  (sum_data),
      .sum_ready (sum_ready)
   );

   pktcls_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (sum_valid),
      .sum_data  (sum_data),
      .sum_ready (sum_ready),
      .dns_port  (dns_port_ff),
      .bgp_port  (bgp_port_ff),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== tb/ipv4_dns_bgp_packet_classifier_tb.sv =====
// Self-checking testbench of the IPv4 DNS/BGP packet classifier
`timescale 1ns / 100ps

module ipv4_dns_bgp_packet_classifier_tb;
   import pktcls_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PCT    = 8;

   // One frame byte waiting for the driver; hold makes the sender wait for all results
   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         hold;
   } frame_word_type;

   logic clock;
   logic reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   pktcls_req_if req_if ();
   pktcls_rsp_if rsp_if ();

   frame_word_type frame_bytes_pending[$];
   result_type     class_results_due[$];

   int  bytes_queued = 0;
   int  bytes_taken  = 0;
   int  cycle_count  = 0;
   int  mismatches   = 0;
   bit  byte_taken   = 1'b0;
   bit  calm         = 1'b0;

   // Classifier copy: port registers and per-frame capture state
   logic [15:0] dns_port_q = DNS_PORT_RESET;
   logic [15:0] bgp_port_q = BGP_PORT_RESET;
   logic [15:0] frame_pos   = '0;
   logic [3:0]  frame_ihl   = '0;
   logic        frame_is_v4 = 1'b0;
   logic [7:0]  frame_proto = '0;
   logic [31:0] frame_src   = '0;
   logic [31:0] frame_dst   = '0;
   logic [31:0] frame_ports = '0;
   logic [15:0] frame_ulen  = '0;
   logic [63:0] frame_dnsh  = '0;

   ipv4_dns_bgp_packet_classifier i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Advance the capture state by one byte; return 1 with the result on the last byte
   function automatic bit classify_frame_byte(input logic [7:0] b, input logic last,
                                              output result_type r);
      int pos, t, have, rel;
      logic [15:0] sp, dp;
      bit is_dns, is_bgp, hdr_ok;
      class_type cls;
      pos = int'(frame_pos);
      r = '0;
      if (pos < MAX_FRAME_BYTES) begin
         if (pos == ETH_HEADER_BYTES) begin
            frame_ihl   = b[3:0];
            frame_is_v4 = (b[7:4] == IP_VERSION_4) && (b[3:0] >= IP_MIN_WORDS);
         end else if (pos == ETH_HEADER_BYTES + 9) begin
            frame_proto = b;
         end else if (pos >= ETH_HEADER_BYTES + 12 && pos < ETH_HEADER_BYTES + 16) begin
            frame_src = {frame_src[23:0], b};
         end else if (pos >= ETH_HEADER_BYTES + 16 && pos < ETH_HEADER_BYTES + 20) begin
            frame_dst = {frame_dst[23:0], b};
         end
         // Transport fields sit behind the variable-length IP header
         if (frame_is_v4) begin
            t = ETH_HEADER_BYTES + 4 * int'(frame_ihl);
            if (pos >= t) begin
               rel = pos - t;
               if (rel < 4)
                  frame_ports = {frame_ports[23:0], b};
               else if (rel < 6)
                  frame_ulen = {frame_ulen[7:0], b};
               else if (rel >= UDP_HDR_BYTES && rel < UDP_HDR_BYTES + 8)
                  frame_dnsh = {frame_dnsh[55:0], b};
            end
         end
      end
      if (frame_pos != 16'hffff)
         frame_pos = frame_pos + 16'd1;
      if (!last)
         return 1'b0;

      have = (pos + 1 > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : pos + 1;
      t = ETH_HEADER_BYTES + 4 * int'(frame_ihl);
      sp = frame_ports[31:16];
      dp = frame_ports[15:0];
      cls = CLASS_NONE;
      // DNS wins over BGP; UDP only carries DNS
      if (frame_is_v4 && have >= t + 4) begin
         is_dns = (sp == dns_port_q) || (dp == dns_port_q);
         is_bgp = (sp == bgp_port_q) || (dp == bgp_port_q);
         if (frame_proto == PROTO_UDP) begin
            if (is_dns) cls = CLASS_DNS_UDP;
         end else if (frame_proto == PROTO_TCP) begin
            if (is_dns) cls = CLASS_DNS_TCP;
            else if (is_bgp) cls = CLASS_BGP_TCP;
         end
      end
      hdr_ok = (cls == CLASS_DNS_UDP) &&
               (int'(frame_ulen) >= UDP_HDR_BYTES + DNS_HDR_BYTES) &&
               (have >= t + UDP_HDR_BYTES + DNS_HDR_BYTES);
      if (cls != CLASS_NONE) begin
         r.traffic_class = cls;
         r.src_addr      = frame_src;
         r.dst_addr      = frame_dst;
         r.src_port_num  = sp;
         r.dst_port_num  = dp;
         if (hdr_ok) begin
            r.dns_header_valid = 1'b1;
            r.dns_id           = frame_dnsh[63:48];
            r.dns_flags        = frame_dnsh[47:32];
            r.dns_questions    = frame_dnsh[31:16];
            r.dns_answers      = frame_dnsh[15:0];
         end
      end
      // Drop the frame state for the next frame
      frame_pos   = '0;
      frame_ihl   = '0;
      frame_is_v4 = 1'b0;
      frame_proto = '0;
      frame_src   = '0;
      frame_dst   = '0;
      frame_ports = '0;
      frame_ulen  = '0;
      frame_dnsh  = '0;
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0h actual %0h", name, want_v, got_v);
         mismatches++;
      end
   endfunction

   // Build one frame around the given header fields; cut > 0 truncates it
   task automatic queue_frame(input logic [3:0] version, input logic [3:0] ihl,
                              input logic [7:0] proto, input logic [31:0] src,
                              input logic [31:0] dst, input logic [15:0] sp,
                              input logic [15:0] dp, input logic [15:0] ulen,
                              input logic [63:0] dns_hdr, input int payload,
                              input int cut, input bit hold);
      int hdr_len, tport, full_len, n;
      logic [7:0] b;
      frame_word_type w;
      hdr_len  = (ihl < IP_MIN_WORDS) ? 20 : 4 * int'(ihl);
      tport    = ETH_HEADER_BYTES + hdr_len;
      full_len = tport + UDP_HDR_BYTES + DNS_HDR_BYTES + payload;
      n = (cut > 0 && cut < full_len) ? cut : full_len;
      for (int i = 0; i < n; i++) begin
         b = 8'($urandom_range(0, 255));
         if (i == ETH_HEADER_BYTES)
            b = {version, ihl};
         else if (i == ETH_HEADER_BYTES + 9)
            b = proto;
         else if (i >= ETH_HEADER_BYTES + 12 && i < ETH_HEADER_BYTES + 16)
            b = src[8 * (ETH_HEADER_BYTES + 15 - i) +: 8];
         else if (i >= ETH_HEADER_BYTES + 16 && i < ETH_HEADER_BYTES + 20)
            b = dst[8 * (ETH_HEADER_BYTES + 19 - i) +: 8];
         else if (i >= tport && i < tport + 2)
            b = sp[8 * (tport + 1 - i) +: 8];
         else if (i >= tport + 2 && i < tport + 4)
            b = dp[8 * (tport + 3 - i) +: 8];
         else if (i >= tport + 4 && i < tport + 6)
            b = ulen[8 * (tport + 5 - i) +: 8];
         else if (i >= tport + 8 && i < tport + 16)
            b = dns_hdr[8 * (tport + 15 - i) +: 8];
         w.data = b;
         w.last = (i == n - 1);
         w.hold = hold && (i == 0);
         frame_bytes_pending.push_back(w);
      end
      bytes_queued += n;
   endtask

   // Half of the time a port that matches a register, else extremes or anything
   function automatic logic [15:0] pick_port();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return dns_port_q;
      if (r < 5) return bgp_port_q;
      if (r == 5) return 16'h0000;
      if (r == 6) return 16'hffff;
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic queue_random_frame();
      int kind, payload, cut, r;
      logic [3:0] version, ihl;
      logic [7:0] proto;
      logic [15:0] ulen;
      kind    = $urandom_range(0, 99);
      version = IP_VERSION_4;
      ihl     = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : IP_MIN_WORDS;
      r = $urandom_range(0, 99);
      proto = (r < 45) ? PROTO_UDP : (r < 90) ? PROTO_TCP : 8'($urandom_range(0, 255));
      payload = $urandom_range(0, 24);
      r = $urandom_range(0, 99);
      if (r < 60)
         ulen = 16'(UDP_HDR_BYTES + DNS_HDR_BYTES + payload);
      else if (r < 80)
         ulen = 16'($urandom_range(0, 24));
      else
         ulen = 16'($urandom_range(0, 65535));
      cut = 0;
      if (kind < 12) begin
         // truncated well-formed frame
         cut = $urandom_range(1, ETH_HEADER_BYTES + 4 * int'(ihl) + 24);
      end else if (kind < 22) begin
         // noise
         version = 4'($urandom_range(0, 15));
         ihl     = 4'($urandom_range(0, 15));
         proto   = 8'($urandom_range(0, 255));
         cut     = $urandom_range(1, 80);
      end
      queue_frame(version, ihl, proto, $urandom, $urandom, pick_port(), pick_port(), ulen,
                  {$urandom, $urandom}, payload, cut, $urandom_range(0, 39) == 0);
   endtask

   task automatic write_port_reg(input logic idx, input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_DNS_PORT)
         dns_port_q = value;
      else
         bgp_port_q = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait for every queued byte to be taken and every result to arrive, then settle
   task automatic wait_drained();
      while (bytes_taken != bytes_queued || class_results_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Queue a burst of random frames under one port setting; the calm burst runs longer
   task automatic run_phase(input logic [15:0] dns_port, input logic [15:0] bgp_port,
                            input bit no_idle);
      int start_bytes, target;
      write_port_reg(CSR_DNS_PORT, dns_port);
      write_port_reg(CSR_BGP_PORT, bgp_port);
      calm = no_idle;
      start_bytes = bytes_queued;
      target = no_idle ? 140 : 40;
      while (bytes_queued - start_bytes < target)
         queue_random_frame();
      wait_drained();
      calm = 1'b0;
   endtask

   // Present the next byte when the channel is free, with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || byte_taken) begin
         if (frame_bytes_pending.size() != 0 &&
             (calm || $urandom_range(0, 99) >= IDLE_PCT) &&
             !(frame_bytes_pending[0].hold && class_results_due.size() != 0)) begin
            req_if.valid      <= 1'b1;
            req_if.frame_byte <= frame_bytes_pending[0].data;
            req_if.frame_last <= frame_bytes_pending[0].last;
            void'(frame_bytes_pending.pop_front());
         end else begin
            req_if.valid <= 1'b0;
         end
      end
      rsp_if.ready <= !reset && (calm || $urandom_range(0, 99) >= IDLE_PCT);
   end

   // Predict on each taken byte, check each result word
   always @(posedge clock) begin
      result_type want, got;
      byte_taken = !reset && req_if.valid && req_if.ready;
      if (byte_taken) begin
         bytes_taken++;
         if (classify_frame_byte(req_if.frame_byte, req_if.frame_last, want))
            class_results_due.push_back(want);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.traffic_class    = rsp_if.traffic_class;
         got.src_addr         = rsp_if.src_addr;
         got.dst_addr         = rsp_if.dst_addr;
         got.src_port_num     = rsp_if.src_port_num;
         got.dst_port_num     = rsp_if.dst_port_num;
         got.dns_header_valid = rsp_if.dns_header_valid;
         got.dns_id           = rsp_if.dns_id;
         got.dns_flags        = rsp_if.dns_flags;
         got.dns_questions    = rsp_if.dns_questions;
         got.dns_answers      = rsp_if.dns_answers;
         if (class_results_due.size() == 0) begin
            $error("result word with no expectation pending");
            mismatches++;
         end else begin
            want = class_results_due.pop_front();
            check_field("traffic_class", 64'(want.traffic_class),
                        64'(got.traffic_class));
            check_field("src_addr", 64'(want.src_addr), 64'(got.src_addr));
            check_field("dst_addr", 64'(want.dst_addr), 64'(got.dst_addr));
            check_field("src_port_num", 64'(want.src_port_num),
                        64'(got.src_port_num));
            check_field("dst_port_num", 64'(want.dst_port_num),
                        64'(got.dst_port_num));
            check_field("dns_header_valid", 64'(want.dns_header_valid),
                        64'(got.dns_header_valid));
            check_field("dns_id", 64'(want.dns_id), 64'(got.dns_id));
            check_field("dns_flags", 64'(want.dns_flags), 64'(got.dns_flags));
            check_field("dns_questions", 64'(want.dns_questions),
                        64'(got.dns_questions));
            check_field("dns_answers", 64'(want.dns_answers), 64'(got.dns_answers));
         end
      end
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_DNS_PORT;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.frame_byte = '0;
      req_if.frame_last = 1'b0;
      rsp_if.ready      = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames under the reset port values
      // valid DNS over UDP, exact length, address extremes
      queue_frame(4'd4, 4'd5, PROTO_UDP, 32'h0, 32'hffffffff, 16'd1024, 16'd53, 16'd20,
                  64'h0123456789abcdef, 0, 0, 1'b0);
      queue_frame(4'd4, 4'd5, PROTO_UDP, 32'hffffffff, 32'h0, 16'd53, 16'h0000, 16'hffff,
                  64'hffffffffffffffff, 5, 0, 1'b0);
      // UDP length too short for a DNS header, and below the UDP header itself
      queue_frame(4'd4, 4'd5, PROTO_UDP, $urandom, $urandom, 16'd53, 16'd53, 16'd19,
                  {$urandom, $urandom}, 4, 0, 1'b0);
      queue_frame(4'd4, 4'd5, PROTO_UDP, $urandom, $urandom, 16'd53, 16'd9, 16'd7,
                  {$urandom, $urandom}, 4, 0, 1'b0);
      queue_frame(4'd4, 4'd5, PROTO_UDP, $urandom, $urandom, 16'd9, 16'd53, 16'd0,
                  {$urandom, $urandom}, 4, 0, 1'b0);
      // frame ends inside the DNS header
      queue_frame(4'd4, 4'd5, PROTO_UDP, $urandom, $urandom, 16'd9, 16'd53, 16'd40,
                  {$urandom, $urandom}, 10, 53, 1'b0);
      // TCP: DNS beats BGP, then BGP on either side
      queue_frame(4'd4, 4'd5, PROTO_TCP, $urandom, $urandom, 16'd53, 16'd179, 16'd40,
                  {$urandom, $urandom}, 2, 0, 1'b0);
      queue_frame(4'd4, 4'd5, PROTO_TCP, $urandom, $urandom, 16'd179, 16'hffff, 16'd40,
                  {$urandom, $urandom}, 2, 0, 1'b0);
      queue_frame(4'd4, 4'd5, PROTO_TCP, $urandom, $urandom, 16'h0000, 16'd179, 16'd40,
                  {$urandom, $urandom}, 2, 0, 1'b0);
      // no class: BGP over UDP, unmatched TCP, other protocol
      queue_frame(4'd4, 4'd5, PROTO_UDP, $urandom, $urandom, 16'd179, 16'd179, 16'd40,
                  {$urandom, $urandom}, 2, 0, 1'b0);
      queue_frame(4'd4, 4'd5, PROTO_TCP, $urandom, $urandom, 16'd80, 16'd443, 16'd40,
                  {$urandom, $urandom}, 2, 0, 1'b0);
      queue_frame(4'd4, 4'd5, 8'd1, $urandom, $urandom, 16'd53, 16'd53, 16'd40,
                  {$urandom, $urandom}, 2, 0, 1'b0);
      queue_frame(4'd4, 4'd5, 8'hff, $urandom, $urandom, 16'd179, 16'd53, 16'd40,
                  {$urandom, $urandom}, 2, 0, 1'b0);
      // not IPv4, short IP header, all-ones version byte
      queue_frame(4'd6, 4'd5, PROTO_UDP, $urandom, $urandom, 16'd53, 16'd53, 16'd20,
                  {$urandom, $urandom}, 0, 0, 1'b0);
      queue_frame(4'd4, 4'd4, PROTO_UDP, $urandom, $urandom, 16'd53, 16'd53, 16'd20,
                  {$urandom, $urandom}, 0, 0, 1'b0);
      queue_frame(4'd4, 4'd0, PROTO_UDP, $urandom, $urandom, 16'd53, 16'd53, 16'd20,
                  {$urandom, $urandom}, 0, 0, 1'b0);
      queue_frame(4'd15, 4'd15, PROTO_UDP, $urandom, $urandom, 16'd53, 16'd53, 16'd20,
                  {$urandom, $urandom}, 0, 0, 1'b0);
      // longest IP header
      queue_frame(4'd4, 4'd15, PROTO_UDP, $urandom, $urandom, 16'd53, 16'd5353, 16'd23,
                  {$urandom, $urandom}, 3, 0, 1'b0);
      // frame ends one byte before the ports are complete, then right after them
      queue_frame(4'd4, 4'd5, PROTO_UDP, $urandom, $urandom, 16'd53, 16'd53, 16'd20,
                  {$urandom, $urandom}, 0, 37, 1'b0);
      queue_frame(4'd4, 4'd5, PROTO_UDP, $urandom, $urandom, 16'd53, 16'd53, 16'd20,
                  {$urandom, $urandom}, 0, 38, 1'b1);
      // single-byte frame and a frame of only the Ethernet header
      queue_frame(4'd4, 4'd5, PROTO_UDP, $urandom, $urandom, 16'd53, 16'd53, 16'd20,
                  {$urandom, $urandom}, 0, 1, 1'b0);
      queue_frame(4'd4, 4'd5, PROTO_UDP, $urandom, $urandom, 16'd53, 16'd53, 16'd20,
                  {$urandom, $urandom}, 0, ETH_HEADER_BYTES, 1'b0);
      wait_drained();

      // Random traffic across port settings, extremes among them
      run_phase(DNS_PORT_RESET, BGP_PORT_RESET, 1'b0);
      run_phase(16'h0000, 16'hffff, 1'b0);
      run_phase(16'hffff, 16'h0000, 1'b1);
      begin
         logic [15:0] shared_port;
         shared_port = 16'($urandom_range(0, 65535));
         run_phase(shared_port, shared_port, 1'b0);
      end
      run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0);

      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
